// ----- rtl/lfd_pkg.sv -----
package lfd_pkg;

  localparam int unsigned LFD_ADDR_W  = 4;
  localparam int unsigned LFD_DATA_W  = 32;
  localparam int unsigned LFD_CNT_W   = 17;

  localparam logic [7:0]  START_BYTE_RST  = 8'h68;
  localparam logic [7:0]  END_BYTE_RST    = 8'h10;
  localparam logic [15:0] SHORT_LIMIT_RST = 16'd512;

  typedef enum logic [1:0] {
    REG_START_BYTE  = 2'd0,
    REG_END_BYTE    = 2'd1,
    REG_SHORT_LIMIT = 2'd2,
    REG_UNUSED      = 2'd3
  } lfd_reg_e;

  typedef enum logic [2:0] {
    ST_IGNORED  = 3'd0,
    ST_STORED   = 3'd1,
    ST_DONE     = 3'd2,
    ST_BAD_TAIL = 3'd3,
    ST_ABORT    = 3'd4
  } lfd_status_e;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_SHORT = 3'b010,
    MODE_LONG  = 3'b100
  } lfd_mode_e;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [15:0] short_frame_limit;
  } lfd_cfg_t;

endpackage

// ----- rtl/lfd_regs.sv -----
module lfd_regs import lfd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [LFD_ADDR_W-1:0] paddr,
  input  logic [LFD_DATA_W-1:0] pwdata,
  output logic [LFD_DATA_W-1:0] prdata,
  output logic                  pready,
  output lfd_cfg_t              cfg_o
);

  lfd_cfg_t cfg_q;
  lfd_reg_e reg_sel;
  logic     wr_en;

  assign reg_sel = lfd_reg_e'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte        <= START_BYTE_RST;
      cfg_q.end_byte          <= END_BYTE_RST;
      cfg_q.short_frame_limit <= SHORT_LIMIT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_START_BYTE:  cfg_q.start_byte        <= pwdata[7:0];
        REG_END_BYTE:    cfg_q.end_byte          <= pwdata[7:0];
        REG_SHORT_LIMIT: cfg_q.short_frame_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_START_BYTE:  prdata = {24'd0, cfg_q.start_byte};
      REG_END_BYTE:    prdata = {24'd0, cfg_q.end_byte};
      REG_SHORT_LIMIT: prdata = {16'd0, cfg_q.short_frame_limit};
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- rtl/lfd_parser.sv -----
module lfd_parser import lfd_pkg::*; #(
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lfd_cfg_t             cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           byte_out_o,
  output logic [LFD_CNT_W-1:0] frame_index_o,
  output logic [2:0]           byte_status_o,
  output logic [LFD_CNT_W-1:0] frame_length_o
);

  localparam logic [LFD_CNT_W-1:0] LenLowPos = LFD_CNT_W'(HEADER_BYTES - 2);
  localparam logic [LFD_CNT_W-1:0] HdrLen    = LFD_CNT_W'(HEADER_BYTES);
  localparam logic [LFD_CNT_W-1:0] LenBias   = LFD_CNT_W'(HEADER_BYTES + 1);

  lfd_mode_e            mode_q, mode_d;
  logic [LFD_CNT_W-1:0] count_q, count_d;
  logic [LFD_CNT_W-1:0] need_q, need_d;
  logic [7:0]           low_q, low_d;

  logic                 out_valid_q;
  logic [7:0]           byte_q;
  logic [LFD_CNT_W-1:0] index_q;
  lfd_status_e          status_q;
  logic [LFD_CNT_W-1:0] length_q;

  logic                 in_fire;
  logic [15:0]          abort_thr;
  logic [LFD_CNT_W-1:0] count_inc;
  logic [LFD_CNT_W-1:0] need_calc;
  lfd_status_e          res_status;
  logic [LFD_CNT_W-1:0] res_index;
  logic [LFD_CNT_W-1:0] res_length;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;

  assign abort_thr = (cfg_i.short_frame_limit >= 16'd2) ?
                     (cfg_i.short_frame_limit - 16'd2) : 16'd0;
  assign count_inc = count_q + LFD_CNT_W'(1);
  assign need_calc = {1'b0, rx_byte_i, low_q} + LenBias;

  always_comb begin
    mode_d     = mode_q;
    count_d    = count_q;
    need_d     = need_q;
    low_d      = low_q;
    res_status = ST_IGNORED;
    res_index  = '0;
    res_length = '0;
    case (mode_q)
      MODE_SHORT: begin
        if (count_q >= {1'b0, abort_thr}) begin
          res_status = ST_ABORT;
          mode_d     = MODE_IDLE;
        end else begin
          res_index  = count_q;
          res_status = ST_STORED;
          count_d    = count_inc;
          if (count_q == LenLowPos) begin
            low_d = rx_byte_i;
          end
          if (count_inc == HdrLen) begin
            need_d = need_calc;
            if (need_calc > {1'b0, cfg_i.short_frame_limit}) begin
              mode_d = MODE_LONG;
            end
          end else if ((need_q != '0) && (count_inc >= need_q)) begin
            res_status = ST_DONE;
            res_length = count_inc;
            mode_d     = MODE_IDLE;
          end
        end
      end
      MODE_LONG: begin
        if (count_q >= need_q) begin
          res_status = ST_ABORT;
          mode_d     = MODE_IDLE;
        end else begin
          res_index  = count_q;
          res_status = ST_STORED;
          count_d    = count_inc;
          if (count_inc >= need_q) begin
            if (rx_byte_i == cfg_i.end_byte) begin
              res_status = ST_DONE;
              res_length = count_inc;
            end else begin
              res_status = ST_BAD_TAIL;
            end
            mode_d = MODE_IDLE;
          end
        end
      end
      default: begin
        mode_d = MODE_IDLE;
        if (rx_byte_i == cfg_i.start_byte) begin
          count_d    = LFD_CNT_W'(1);
          need_d     = '0;
          mode_d     = MODE_SHORT;
          res_status = ST_STORED;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      count_q     <= '0;
      need_q      <= '0;
      low_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_q  <= mode_d;
        count_q <= count_d;
        need_q  <= need_d;
        low_q   <= low_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q   <= rx_byte_i;
      index_q  <= res_index;
      status_q <= res_status;
      length_q <= res_length;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_out_o     = byte_q;
  assign frame_index_o  = index_q;
  assign byte_status_o  = status_q;
  assign frame_length_o = length_q;

  a_mode_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(mode_q))
    else $error("Parser mode register is not one-hot.");

  a_long_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_LONG) |-> (count_q < need_q))
    else $error("Long frame count reached its length without closing.");

  a_short_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_SHORT) |-> (count_q != '0))
    else $error("Short frame count is zero inside a frame.");

  a_close_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (res_status == ST_DONE || res_status == ST_BAD_TAIL ||
                 res_status == ST_ABORT)) |=> (mode_q == MODE_IDLE))
    else $error("Parser did not return to idle after closing a frame.");

  a_unstored_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == ST_IGNORED || status_q == ST_ABORT)) |->
    (index_q == '0 && length_q == '0))
    else $error("Unstored byte carries a nonzero index or length.");

endmodule

// ----- rtl/length_framed_byte_deframer_top.sv -----
// Byte deframer for a length-framed serial protocol. The result of each byte
// that is accepted (the byte, its frame index, a status code and, on
// completion, the frame length) appears in the output register
// on the next cycle; the input side takes a new byte every cycle unless the
// output register is full and not being taken. The rate of one byte per cycle
// is set by the single parser stage that updates the frame state on each
// transaction. Frames open on the start byte, carry a little-endian payload
// length in the last two header bytes, and are checked against the end byte
// only when longer than the short frame limit. The registers start_byte,
// end_byte and short_frame_limit sit at byte addresses 0, 4 and 8 and should
// be written only while no frame is in progress.
module length_framed_byte_deframer_top import lfd_pkg::*; #(
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [LFD_ADDR_W-1:0] paddr,
  input  logic [LFD_DATA_W-1:0] pwdata,
  output logic [LFD_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            rx_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            byte_out_o,
  output logic [LFD_CNT_W-1:0]  frame_index_o,
  output logic [2:0]            byte_status_o,
  output logic [LFD_CNT_W-1:0]  frame_length_o
);

  lfd_cfg_t cfg;

  lfd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lfd_parser #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .byte_out_o     (byte_out_o),
    .frame_index_o  (frame_index_o),
    .byte_status_o  (byte_status_o),
    .frame_length_o (frame_length_o)
  );

endmodule
